### rtl/dsw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dsw_pkg: shared constants and types for the dice sum way counter
// Sizes of the dice-by-sum table, field widths, and the request structs
// that pass between the sequencer, the row memory and the add/sub unit.
// ============================================================================
package dsw_pkg;

    localparam int MAX_DICE  = 16;
    localparam int MAX_SUM   = 256;
    localparam int ROW_LEN   = MAX_SUM + 1;
    localparam int MEM_DEPTH = 2 * ROW_LEN;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int COL_W     = $clog2(MAX_SUM + 1);
    localparam int ROW_W     = $clog2(MAX_DICE + 1);

    localparam int FACES_W = 9;
    localparam int DICE_W  = 5;
    localparam int SUM_W   = 9;
    localparam int WAYS_W  = 64;

    // Common width for range checks between fields and table indexes.
    localparam int CMP_W = 16;

    typedef logic [WAYS_W-1:0] t_ways;
    typedef logic [MEM_AW-1:0] t_addr;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_ways wdata;
        logic  re;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_mem_req;

    typedef struct packed {
        t_ways a;
        t_ways b;
        logic  sub;
    } t_alu_req;

    typedef struct packed {
        logic  valid;
        t_ways ways;
    } t_res;

endpackage

### rtl/dsw_row_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// dsw_row_mem: two table rows of 64-bit counts
// One write port and two read ports with registered read data.
// ============================================================================
module dsw_row_mem (
    input  logic              i_clk,
    input  dsw_pkg::t_mem_req i_req,
    output dsw_pkg::t_ways    o_rd_a,
    output dsw_pkg::t_ways    o_rd_b
);

    dsw_pkg::t_ways r_mem [dsw_pkg::MEM_DEPTH];
    dsw_pkg::t_ways r_rd_a;
    dsw_pkg::t_ways r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_a <= r_mem[i_req.raddr_a];
            r_rd_b <= r_mem[i_req.raddr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

### rtl/dsw_addsub.sv
`timescale 1ns / 1ps
// ============================================================================
// dsw_addsub: shared 64-bit adder/subtractor
// Adds or subtracts modulo 2^64; the sequencer uses it twice per cell from the row index on.
// ============================================================================
module dsw_addsub (
    input  dsw_pkg::t_alu_req i_req,
    output dsw_pkg::t_ways    o_y
);

    always_comb begin
        if (i_req.sub) begin
            o_y = i_req.a - i_req.b;
        end else begin
            o_y = i_req.a + i_req.b;
        end
    end

endmodule

### rtl/dsw_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// dsw_seq: cell sequencer for the dice sum way counter
// Walks the table row by row, reading the row above, driving the shared
// add/sub unit and writing each cell into the other row buffer.
// ============================================================================
module dsw_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dsw_pkg::FACES_W-1:0]   i_faces,
    input  logic [dsw_pkg::DICE_W-1:0]    i_dice,
    input  logic [dsw_pkg::SUM_W-1:0]     i_target_sum,
    output dsw_pkg::t_mem_req             o_mem,
    input  dsw_pkg::t_ways                i_rd_a,
    input  dsw_pkg::t_ways                i_rd_b,
    output dsw_pkg::t_alu_req             o_alu,
    input  dsw_pkg::t_ways                i_alu_y,
    output dsw_pkg::t_res                 o_res,
    input  logic                          i_res_take
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RD,
        S_ADD,
        S_SUB,
        S_DONE
    } t_state;

    t_state                           r_state;
    logic [dsw_pkg::FACES_W-1:0]      r_faces;
    logic [dsw_pkg::ROW_W-1:0]        r_dice;
    logic [dsw_pkg::COL_W-1:0]        r_target;
    logic [dsw_pkg::ROW_W-1:0]        r_row;
    logic [dsw_pkg::COL_W-1:0]        r_col;
    logic                             r_cur;
    logic                             r_use_sub;
    dsw_pkg::t_ways                   r_left;
    dsw_pkg::t_ways                   r_acc;

    logic                             accept;
    logic                             refused;
    logic                             col_last;
    logic                             row_last;
    logic                             col_below_row;
    logic                             window_full;
    logic [dsw_pkg::CMP_W-1:0]        back_col;
    dsw_pkg::t_ways                   init_val;

    function automatic dsw_pkg::t_addr row_addr(input logic bank,
                                                input logic [dsw_pkg::COL_W-1:0] col);
        dsw_pkg::t_addr base;
        base = bank ? dsw_pkg::MEM_AW'(dsw_pkg::ROW_LEN) : '0;
        return base + dsw_pkg::MEM_AW'(col);
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign refused = (dsw_pkg::CMP_W'(i_dice) > dsw_pkg::CMP_W'(dsw_pkg::MAX_DICE)) ||
                     (dsw_pkg::CMP_W'(i_target_sum) > dsw_pkg::CMP_W'(dsw_pkg::MAX_SUM));

    assign col_last      = (r_col == r_target);
    assign row_last      = (r_row == r_dice);
    assign col_below_row = dsw_pkg::CMP_W'(r_col) < dsw_pkg::CMP_W'(r_row);
    assign window_full   = dsw_pkg::CMP_W'(r_col) > dsw_pkg::CMP_W'(r_faces);
    assign back_col      = dsw_pkg::CMP_W'(r_col) - dsw_pkg::CMP_W'(r_faces) -
                           dsw_pkg::CMP_W'(1);
    assign init_val      = (r_col == '0) ? dsw_pkg::t_ways'(1) : '0;

    // Memory and add/sub requests follow the phase of the current cell.
    always_comb begin
        o_mem         = '0;
        o_mem.raddr_a = row_addr(r_cur, r_col - dsw_pkg::COL_W'(1));
        o_mem.raddr_b = o_mem.raddr_a;
        if (window_full) begin
            o_mem.raddr_b = row_addr(r_cur, dsw_pkg::COL_W'(back_col));
        end
        o_alu = '0;
        case (r_state)
            S_INIT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = row_addr(r_cur, r_col);
                o_mem.wdata = init_val;
            end
            S_RD: begin
                o_mem.we    = col_below_row;
                o_mem.waddr = row_addr(~r_cur, r_col);
                o_mem.re    = !col_below_row;
            end
            S_ADD: begin
                o_alu.a = r_left;
                o_alu.b = i_rd_a;
            end
            S_SUB: begin
                o_alu.a     = r_acc;
                o_alu.b     = r_use_sub ? i_rd_b : '0;
                o_alu.sub   = 1'b1;
                o_mem.we    = 1'b1;
                o_mem.waddr = row_addr(~r_cur, r_col);
                o_mem.wdata = i_alu_y;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_cur   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_faces  <= i_faces;
                        r_dice   <= dsw_pkg::ROW_W'(i_dice);
                        r_target <= dsw_pkg::COL_W'(i_target_sum);
                        r_row    <= '0;
                        r_col    <= '0;
                        r_cur    <= 1'b0;
                        if (refused) begin
                            r_left  <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_left <= init_val;
                    if (col_last) begin
                        r_col <= '0;
                        if (r_dice == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_row   <= dsw_pkg::ROW_W'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_col <= r_col + dsw_pkg::COL_W'(1);
                    end
                end
                S_RD: begin
                    r_use_sub <= window_full;
                    if (col_below_row) begin
                        r_left <= '0;
                        if (col_last) begin
                            r_col <= '0;
                            r_cur <= ~r_cur;
                            if (row_last) begin
                                r_state <= S_DONE;
                            end else begin
                                r_row <= r_row + dsw_pkg::ROW_W'(1);
                            end
                        end else begin
                            r_col <= r_col + dsw_pkg::COL_W'(1);
                        end
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_acc   <= i_alu_y;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_left  <= i_alu_y;
                    r_state <= S_RD;
                    if (col_last) begin
                        r_col <= '0;
                        r_cur <= ~r_cur;
                        if (row_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_row <= r_row + dsw_pkg::ROW_W'(1);
                        end
                    end else begin
                        r_col <= r_col + dsw_pkg::COL_W'(1);
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The last cell written is the one at the target sum in the final row.
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.ways  = r_left;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT || r_state == S_RD || r_state == S_ADD || r_state == S_SUB)
        |-> (r_col <= r_target))
        else $error("column index ran past the target sum");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_ADD || r_state == S_SUB)
        |-> (r_row != '0 && r_row <= r_dice))
        else $error("row index out of range");

    a_write_other_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB && !r_cur)
        |-> (o_mem.waddr >= dsw_pkg::MEM_AW'(dsw_pkg::ROW_LEN)))
        else $error("cell written into the row being read");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && refused) |=> (r_state == S_DONE && r_left == '0))
        else $error("out-of-range query did not return zero");

    a_add_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ($past(r_state) == S_RD && $past(o_mem.re)))
        else $error("add phase without a preceding row read");

endmodule

### rtl/dice_sum_way_counter.sv
`timescale 1ns / 1ps
// The walk first initialises row 0 over columns 0 to T, then for each die row handles
// every column up to T: a column below the row index is written as zero in the read
// state, every other one passes through the read, add and subtract states; the result
// is then handed over to the output register.
// Throughput: one query at a time; the three-phase cell loop around the shared
// 64-bit add/sub unit and the two-port row memory sets the rate.
// Reset: synchronous active-low i_rst_n clears the sequencer and the output valid only.
// ============================================================================
// dice_sum_way_counter: counts ordered dice outcomes that reach a target sum
// Fills a dice-by-sum table with the sliding-window recurrence, two rows at
// a time, and returns the count modulo 2^64.
// ============================================================================
module dice_sum_way_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dsw_pkg::FACES_W-1:0]  i_faces,
    input  logic [dsw_pkg::DICE_W-1:0]   i_dice,
    input  logic [dsw_pkg::SUM_W-1:0]    i_target_sum,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dsw_pkg::WAYS_W-1:0]   o_ways
);

    dsw_pkg::t_mem_req  mem_req;
    dsw_pkg::t_alu_req  alu_req;
    dsw_pkg::t_ways     rd_a;
    dsw_pkg::t_ways     rd_b;
    dsw_pkg::t_ways     alu_y;
    dsw_pkg::t_res      res;
    logic               res_take;

    logic               r_out_valid;
    dsw_pkg::t_ways     r_ways;

    // The sequencer owns the table walk. It holds its finished count until
    // the output register has room for it.
    dsw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_faces      (i_faces),
        .i_dice       (i_dice),
        .i_target_sum (i_target_sum),
        .o_mem        (mem_req),
        .i_rd_a       (rd_a),
        .i_rd_b       (rd_b),
        .o_alu        (alu_req),
        .i_alu_y      (alu_y),
        .o_res        (res),
        .i_res_take   (res_take)
    );

    // Two row buffers: the row above is read on both ports while the new
    // row is written into the other half.
    dsw_row_mem u_row_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // One adder/subtractor serves both steps of every cell from the row index on: first the left
    // neighbor plus the upper-left entry, then minus the entry that drops
    // out of the window.
    dsw_addsub u_addsub (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    // The output register frees the sequencer to start the next query while
    // the last result beat still waits on the output channel.
    assign res_take = res.valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_ways <= res.ways;
        end
    end

    assign o_valid = r_out_valid;
    assign o_ways  = r_ways;

endmodule
